// File: design/ple_pkg.sv
// ple_pkg: shared types and codes for the positional list engine
// request and result transaction structs, function codes, status codes
// no dependencies

package ple_pkg;

  localparam int unsigned ValueW = 32;
  localparam int unsigned FuncW  = 3;
  localparam int unsigned PosW   = 5;
  localparam int unsigned CountW = 5;

  localparam logic [FuncW-1:0] FN_INS_TAIL = 3'd0;
  localparam logic [FuncW-1:0] FN_INS_HEAD = 3'd1;
  localparam logic [FuncW-1:0] FN_INS_AT   = 3'd2;
  localparam logic [FuncW-1:0] FN_READ_AT  = 3'd3;
  localparam logic [FuncW-1:0] FN_DEL_HEAD = 3'd4;
  localparam logic [FuncW-1:0] FN_DEL_TAIL = 3'd5;
  localparam logic [FuncW-1:0] FN_DEL_AT   = 3'd6;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  typedef struct packed {
    logic [FuncW-1:0]         func;
    logic [PosW-1:0]          position;
    logic signed [ValueW-1:0] item_value;
  } in_item_t;

  typedef struct packed {
    logic signed [ValueW-1:0] read_value;
    logic [1:0]               status;
    logic [CountW-1:0]        element_count;
  } out_item_t;

  typedef struct packed {
    logic                     ins;
    logic                     del;
    logic signed [ValueW-1:0] value;
  } cell_ctrl_t;

  typedef struct packed {
    status_e           status;
    logic              rd_ok;
    logic [CountW-1:0] element_count;
  } ctrl_rsp_t;

endpackage

// File: design/ple_cell.sv
// ple_cell: one list slot, holds one element and shifts to or from its neighbors
// depends on ple_pkg

module ple_cell import ple_pkg::*; #(
  parameter int unsigned Idx   = 0,
  parameter int unsigned CmpW  = 5
) (
  input  logic                     clk_i,
  input  cell_ctrl_t               ctrl_i,
  input  logic [CmpW-1:0]          pos_i,
  input  logic signed [ValueW-1:0] prev_i,
  input  logic signed [ValueW-1:0] next_i,
  output logic signed [ValueW-1:0] val_o,
  output logic signed [ValueW-1:0] rd_o
);

  localparam logic [CmpW-1:0] MyIdx = CmpW'(Idx);

  logic signed [ValueW-1:0] val_q, val_d;

  always_comb begin
    val_d = val_q;
    if (ctrl_i.ins) begin
      if (MyIdx > pos_i) begin
        val_d = prev_i;
      end else if (MyIdx == pos_i) begin
        val_d = ctrl_i.value;
      end
    end else if (ctrl_i.del) begin
      if (MyIdx >= pos_i) begin
        val_d = next_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;
  assign rd_o  = (MyIdx == pos_i) ? val_q : '0;

endmodule

// File: design/ple_ctrl.sv
// ple_ctrl: request decode, range and fill checks, element count register
// depends on ple_pkg

module ple_ctrl import ple_pkg::*; #(
  parameter int unsigned Capacity = 16,
  parameter int unsigned CmpW     = 5
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            fire_i,
  input  in_item_t        req_i,
  output cell_ctrl_t      cell_o,
  output logic [CmpW-1:0] pos_o,
  output ctrl_rsp_t       rsp_o
);

  localparam int unsigned CntW = $clog2(Capacity + 1);
  localparam logic [CntW-1:0] CapCnt = CntW'(Capacity);

  logic [CntW-1:0] count_q, count_d;
  logic [CmpW-1:0] cnt_ext, pos_in, pos_sel, cnt_after;
  logic            is_ins, is_del, is_rd, ok;
  status_e         status;

  assign cnt_ext = CmpW'(count_q);
  assign pos_in  = CmpW'(req_i.position);

  always_comb begin
    is_ins  = 1'b0;
    is_del  = 1'b0;
    is_rd   = 1'b0;
    pos_sel = '0;
    case (req_i.func)
      FN_INS_TAIL: begin
        is_ins  = 1'b1;
        pos_sel = cnt_ext;
      end
      FN_INS_HEAD: begin
        is_ins  = 1'b1;
      end
      FN_INS_AT: begin
        is_ins  = 1'b1;
        pos_sel = pos_in;
      end
      FN_READ_AT: begin
        is_rd   = 1'b1;
        pos_sel = pos_in;
      end
      FN_DEL_HEAD: begin
        is_del  = 1'b1;
      end
      FN_DEL_TAIL: begin
        is_del  = 1'b1;
        pos_sel = cnt_ext - CmpW'(1);
      end
      FN_DEL_AT: begin
        is_del  = 1'b1;
        pos_sel = pos_in;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    status = ST_OK;
    if (is_ins) begin
      if (count_q >= CapCnt) begin
        status = ST_FULL;
      end else if (pos_sel > cnt_ext) begin
        status = ST_RANGE;
      end
    end else if (is_rd || is_del) begin
      if (count_q == '0) begin
        status = ST_EMPTY;
      end else if (pos_sel >= cnt_ext) begin
        status = ST_RANGE;
      end
    end
  end

  assign ok = (status == ST_OK);

  always_comb begin
    count_d = count_q;
    if (is_ins && ok) begin
      count_d = count_q + CntW'(1);
    end else if (is_del && ok) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (fire_i) begin
      count_q <= count_d;
    end
  end

  assign cnt_after = CmpW'(count_d);

  assign cell_o.ins   = fire_i && is_ins && ok;
  assign cell_o.del   = fire_i && is_del && ok;
  assign cell_o.value = req_i.item_value;
  assign pos_o        = pos_sel;

  assign rsp_o.status        = status;
  assign rsp_o.rd_ok         = is_rd && ok;
  assign rsp_o.element_count = cnt_after[CountW-1:0];

endmodule

// File: design/positional_list_engine.sv
// positional_list_engine: bounded ordered list with insert, read and delete at any position
// row of ple_cell slots driven by ple_ctrl, registered result stage; depends on ple_pkg
//
//   channel | valid      | stall       | payload
//   request | in_valid_i | in_stall_o  | in_item_i  (in_item_t)
//   result  | out_valid_o| out_stall_i | out_item_o (out_item_t)
//
// one request per cycle unless stalled; slots shift on the edge that takes the request
// the result appears in the output register in the cycle after acceptance
// requests are taken while a result waits unless the result side stalls
// reset clears the count and the output valid; slot contents are not reset

module positional_list_engine import ple_pkg::*; #(
  parameter int unsigned Capacity = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  localparam int unsigned CntW = $clog2(Capacity + 1);
  localparam int unsigned CmpW = (CntW > PosW) ? CntW : PosW;
  localparam logic [CmpW-1:0] CapExt = CmpW'(Capacity);

  logic                     fire;
  cell_ctrl_t               cell_ctrl;
  logic [CmpW-1:0]          pos;
  ctrl_rsp_t                rsp;
  logic signed [ValueW-1:0] cell_val [Capacity];
  logic signed [ValueW-1:0] cell_rd  [Capacity];
  logic signed [ValueW-1:0] rd_any;
  logic                     out_valid_q;
  out_item_t                out_item_q, out_item_d;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign fire       = in_valid_i && !in_stall_o;

  ple_ctrl #(
    .Capacity (Capacity),
    .CmpW     (CmpW)
  ) u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .req_i  (in_item_i),
    .cell_o (cell_ctrl),
    .pos_o  (pos),
    .rsp_o  (rsp)
  );

  for (genvar i = 0; i < Capacity; i++) begin : g_cell
    logic signed [ValueW-1:0] prev, next;
    if (i == 0) begin : g_first
      assign prev = cell_ctrl.value;
    end else begin : g_prev
      assign prev = cell_val[i-1];
    end
    if (i == Capacity - 1) begin : g_last
      assign next = '0;
    end else begin : g_next
      assign next = cell_val[i+1];
    end
    ple_cell #(
      .Idx  (i),
      .CmpW (CmpW)
    ) u_cell (
      .clk_i  (clk_i),
      .ctrl_i (cell_ctrl),
      .pos_i  (pos),
      .prev_i (prev),
      .next_i (next),
      .val_o  (cell_val[i]),
      .rd_o   (cell_rd[i])
    );
  end

  always_comb begin
    rd_any = '0;
    for (int i = 0; i < Capacity; i++) begin
      rd_any = rd_any | cell_rd[i];
    end
  end

  always_comb begin
    out_item_d.read_value    = rsp.rd_ok ? rd_any : '0;
    out_item_d.status        = rsp.status;
    out_item_d.element_count = rsp.element_count;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

`ifndef SYNTHESIS
  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("request stalled without a pending result");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.status == ST_FULL) |->
      (out_item_o.element_count == CapExt[CountW-1:0]))
    else $error("full status with count below capacity");

  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.status == ST_EMPTY) |-> (out_item_o.element_count == '0))
    else $error("empty status with nonzero count");

  a_read_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.read_value != '0) |-> (out_item_o.status == ST_OK))
    else $error("read value returned with error status");
`endif

endmodule

// File: verif/positional_list_engine_tb.sv
// positional_list_engine_tb: self-checking testbench for the positional list engine
// predicts each result from a queue image of the list, checks results in order
// depends on ple_pkg and positional_list_engine
`timescale 1ns / 100ps

module positional_list_engine_tb;
  import ple_pkg::*;

  localparam int unsigned Capacity    = 16;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned HoldCycles  = 150;
  localparam int unsigned DrainCycles = 10;
  localparam int unsigned PhaseItems  = 400;
  localparam logic [FuncW-1:0] FnUnused = 3'd7;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_item_t  in_item_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_item_o;

  logic signed [ValueW-1:0] list_image[$];
  out_item_t                predicted_results[$];
  out_item_t                want_r;
  int unsigned              error_cnt = 0;
  int unsigned              cycle_cnt = 0;
  int unsigned              send_idle_pct = 0;
  int unsigned              recv_idle_pct = 0;
  logic                     hold_on = 1'b0;
  event                     hold_go;

  positional_list_engine #(.Capacity(Capacity)) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("positional_list_engine: mismatch");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t %s: got %0h want %0h", $time, what, got, want);
    error_cnt++;
  endtask

  function automatic status_e insert_at(input int unsigned pos,
                                        input logic signed [ValueW-1:0] value);
    if (list_image.size() >= Capacity) return ST_FULL;
    if (pos > list_image.size()) return ST_RANGE;
    list_image.insert(pos, value);
    return ST_OK;
  endfunction

  function automatic status_e delete_at(input int unsigned pos);
    if (list_image.size() == 0) return ST_EMPTY;
    if (pos >= list_image.size()) return ST_RANGE;
    list_image.delete(pos);
    return ST_OK;
  endfunction

  function automatic out_item_t apply_request(input in_item_t rq);
    out_item_t   r;
    status_e     st;
    int unsigned n;
    r  = '0;
    st = ST_OK;
    n  = list_image.size();
    case (rq.func)
      FN_INS_TAIL: st = insert_at(n, rq.item_value);
      FN_INS_HEAD: st = insert_at(0, rq.item_value);
      FN_INS_AT:   st = insert_at(32'(rq.position), rq.item_value);
      FN_READ_AT: begin
        if (n == 0) st = ST_EMPTY;
        else if (rq.position >= n) st = ST_RANGE;
        else r.read_value = list_image[rq.position];
      end
      FN_DEL_HEAD: st = delete_at(0);
      FN_DEL_TAIL: st = (n == 0) ? ST_EMPTY : delete_at(n - 1);
      FN_DEL_AT:   st = delete_at(32'(rq.position));
      default: ;
    endcase
    r.status        = st;
    r.element_count = CountW'(list_image.size());
    return r;
  endfunction

  // result check first: a transaction accepted now answers on a later edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (predicted_results.size() == 0) begin
          report_mismatch("unexpected result", out_item_o.read_value, 32'd0);
        end else begin
          want_r = predicted_results.pop_front();
          if (out_item_o.read_value !== want_r.read_value)
            report_mismatch("read_value", out_item_o.read_value, want_r.read_value);
          if (out_item_o.status !== want_r.status)
            report_mismatch("status", 32'(out_item_o.status), 32'(want_r.status));
          if (out_item_o.element_count !== want_r.element_count)
            report_mismatch("element_count", 32'(out_item_o.element_count),
                            32'(want_r.element_count));
        end
      end
      if (in_valid_i && !in_stall_o) predicted_results.push_back(apply_request(in_item_i));
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= hold_on || ($urandom_range(99) < recv_idle_pct);
    end
  end

  always begin
    @(hold_go);
    hold_on <= 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    hold_on <= 1'b0;
  end

  task automatic issue_request(input logic [FuncW-1:0] func, input logic [PosW-1:0] pos,
                               input logic signed [ValueW-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i          <= 1'b1;
    in_item_i.func       <= func;
    in_item_i.position   <= pos;
    in_item_i.item_value <= value;
    do @(posedge clk_i); while (!(in_valid_i && !in_stall_o));
  endtask

  task automatic issue_random(input int unsigned ins_pct);
    int unsigned              n;
    int unsigned              roll;
    logic [FuncW-1:0]         func;
    logic [PosW-1:0]          pos;
    logic signed [ValueW-1:0] value;
    n    = list_image.size();
    roll = $urandom_range(99);
    if (roll < ins_pct) begin
      case ($urandom_range(2))
        0: func = FN_INS_TAIL;
        1: func = FN_INS_HEAD;
        default: func = FN_INS_AT;
      endcase
    end else if (roll < 98) begin
      case ($urandom_range(4))
        0, 1: func = FN_READ_AT;
        2: func = FN_DEL_HEAD;
        3: func = FN_DEL_TAIL;
        default: func = FN_DEL_AT;
      endcase
    end else begin
      func = FnUnused;
    end
    case ($urandom_range(9))
      0: pos = PosW'($urandom_range(31));
      1: pos = PosW'(n);
      default: pos = PosW'($urandom_range(n > 0 ? n - 1 : 0));
    endcase
    case ($urandom_range(7))
      0: value = 32'sh8000_0000;
      1: value = 32'sh7fff_ffff;
      2: value = '0;
      3: value = -1;
      default: value = $urandom();
    endcase
    issue_request(func, pos, value);
  endtask

  task automatic test_empty_list();
    issue_request(FN_READ_AT, 0, 32'sd1);
    issue_request(FN_DEL_HEAD, 0, 32'sd2);
    issue_request(FN_DEL_TAIL, 0, 32'sd3);
    issue_request(FN_DEL_AT, 0, 32'sd4);
    issue_request(FN_INS_AT, 1, 32'sd5);
    issue_request(FnUnused, 5'd31, -1);
  endtask

  task automatic test_edit_positions();
    issue_request(FN_INS_TAIL, 0, 32'sh7fff_ffff);
    issue_request(FN_INS_HEAD, 0, 32'sh8000_0000);
    issue_request(FN_INS_AT, 1, '0);
    issue_request(FN_INS_AT, 3, -1);
    issue_request(FN_INS_AT, 5, 32'sh1234_5678);
    issue_request(FN_INS_AT, 5'd31, 32'sh5555_5555);
    issue_request(FN_INS_AT, 0, 32'shaaaa_aaaa);
    issue_request(FN_READ_AT, 0, '0);
    issue_request(FN_READ_AT, 1, '0);
    issue_request(FN_READ_AT, 4, '0);
    issue_request(FN_READ_AT, 5, '0);
    issue_request(FN_READ_AT, 5'd31, '0);
    issue_request(FN_DEL_AT, 2, '0);
    issue_request(FN_DEL_AT, 4, '0);
    issue_request(FN_DEL_HEAD, 0, '0);
    issue_request(FN_DEL_TAIL, 0, '0);
    issue_request(FnUnused, 0, 32'sh0f0f_0f0f);
  endtask

  task automatic test_full_list();
    repeat (Capacity) issue_request(FN_INS_HEAD, 0, $urandom());
    issue_request(FN_INS_TAIL, 0, -1);
    issue_request(FN_INS_AT, 5'd31, -1);
    issue_request(FN_INS_AT, 0, -1);
    issue_request(FN_READ_AT, PosW'(Capacity - 1), '0);
    issue_request(FN_DEL_AT, PosW'(Capacity - 1), '0);
    issue_request(FN_INS_AT, PosW'(Capacity - 1), 32'sh7fff_ffff);
    repeat (Capacity) issue_request(FN_DEL_TAIL, 0, '0);
    issue_request(FN_DEL_HEAD, 0, '0);
  endtask

  // receiver holds off while random requests keep coming, so the input stalls
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    -> hold_go;
    repeat (40) issue_random(60);
  endtask

  // insert bias swings so the list keeps running between empty and full
  task automatic test_random_mix(input int unsigned send_pct, input int unsigned recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int unsigned i = 0; i < PhaseItems; i++) begin
      issue_random(((i / 50) % 2 == 0) ? 70 : 25);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_list();
    test_edit_positions();
    test_full_list();
    test_random_mix(13, 64);
    test_backpressure();
    test_random_mix(64, 13);
    test_random_mix(0, 0);
    in_valid_i <= 1'b0;
    while (predicted_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (error_cnt == 0) begin
      $display("positional_list_engine: match");
    end else begin
      $display("positional_list_engine: mismatch");
    end
    $finish;
  end

endmodule
